// ===== hw/rtl/mspr_pkg.sv =====
// mspr_pkg: types and constants shared by the motor speed PI regulator.
// Used by the channel interfaces, the clamp stage and the top level.
package mspr_pkg;

  localparam int unsigned RpmW     = 17;
  localparam int unsigned ErrW     = 18;
  localparam int unsigned DeltaW   = 19;
  localparam int unsigned SumW     = 25;
  localparam int unsigned GainW    = 20;
  localparam int unsigned DutyW    = 15;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 20;

  // Q16 drive sum and the bounds that sit on it
  localparam int unsigned DriveW   = 48;
  localparam logic signed [DriveW-1:0] DriveMax = 48'sd648806400; // 99 % * 100 in Q16

  // duty = floor(drive / 25600) = floor((drive >> 10) / 25)
  localparam int unsigned DivShift   = 10;
  localparam int unsigned QuotW      = 20;
  localparam int unsigned RecipW     = 22;
  localparam int unsigned RecipShift = 26;
  localparam logic [RecipW-1:0] Recip = 22'd2684355; // ceil(2^26 / 25)

  localparam logic [DutyW-1:0] DutyMax = 15'd25344;   // 99.0 in Q7.8

  localparam logic signed [SumW-1:0] SumLimit = 25'sd10000000;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgKp = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgKi = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgKd = 2'd2;

  localparam logic [GainW-1:0] KpReset = 20'd45875;
  localparam logic [GainW-1:0] KiReset = 20'd328;
  localparam logic [GainW-1:0] KdReset = 20'd0;

  typedef struct packed {
    logic [RpmW-1:0] set_rpm;
    logic            set_direction;
    logic [RpmW-1:0] measured_rpm;
  } in_item_t;

  typedef struct packed {
    logic [DutyW-1:0] duty;
    logic             brake;
    logic             drive_pin_a;
    logic             drive_pin_h;
  } out_item_t;

  typedef struct packed {
    logic             sat_max;
    logic [QuotW-1:0] quot_in;
  } clamp_t;

endpackage

// ===== hw/rtl/mspr_in_if.sv =====
// mspr_in_if: valid/ready channel carrying one control tick.
// Depends on mspr_pkg for the item type.
interface mspr_in_if import mspr_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/mspr_out_if.sv =====
// mspr_out_if: valid/ready channel carrying one regulator result.
// Depends on mspr_pkg for the item type.
interface mspr_out_if import mspr_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/motor_speed_pi_regulator_top.sv =====
// motor_speed_pi_regulator_top: PI(D) speed regulator with clamped error sum.
// Depends on mspr_pkg, mspr_in_if, mspr_out_if and mspr_drive_clamp.
//
// Usage:
//   in_i carries one control tick (set_rpm, set_direction, measured_rpm);
//   out_o returns one result per tick (duty in Q7.8, brake, bridge pins).
//   A transfer happens on a rising edge with valid and ready both high.
//   Gains are written through cfg_we_i / cfg_idx_i / cfg_data_i while idle;
//   index 0 = proportional, 1 = integral, 2 = derivative, others ignored.
// Timing:
//   Four-stage pipeline: error and state update, three gain multiplies,
//   sum and clamp, reciprocal divide into the output register. A result
//   passes the stage 1, 2 and 3 registers and then out_q before out_o.valid
//   rises. One tick per cycle is sustained while out_o.ready stays high; the
//   error sum and previous error are updated at the input transfer itself,
//   so consecutive ticks never wait on each other.
// Reset:
//   Error sum and previous error clear, direction is H, gains return to
//   0.7 / 0.005 / 0.0, the pipeline empties.
// Stall:
//   Each stage holds while the one after it is full and blocked, so empty
//   stages still fill; in_i.ready falls only once all four stages are full.
module motor_speed_pi_regulator_top import mspr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  mspr_in_if.sink             in_i,
  mspr_out_if.source          out_o
);

  localparam int unsigned PpW = GainW + 1 + ErrW;
  localparam int unsigned PiW = GainW + 1 + SumW;
  localparam int unsigned PdW = GainW + 1 + DeltaW;
  localparam int unsigned ProdW = QuotW + RecipW;

  // configuration
  logic [GainW-1:0] kp_q, ki_q, kd_q;

  // regulator state
  logic signed [SumW-1:0] err_sum_q;
  logic signed [ErrW-1:0] prev_err_q;
  logic                   dir_q;

  // pipeline
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;
  logic in_acc;

  logic signed [ErrW-1:0]   s1_err_q;
  logic signed [SumW-1:0]   s1_sum_q;
  logic signed [DeltaW-1:0] s1_delta_q;
  logic                     s1_brake_q, s1_dir_q;

  logic signed [PpW-1:0] s2_pp_q;
  logic signed [PiW-1:0] s2_pi_q;
  logic signed [PdW-1:0] s2_pd_q;
  logic                  s2_brake_q, s2_dir_q;

  clamp_t s3_clamp_q;
  logic   s3_brake_q, s3_dir_q;

  out_item_t out_q;

  // combinational
  logic signed [ErrW-1:0]   err_d;
  logic signed [DeltaW-1:0] delta_d;
  logic signed [SumW:0]     sum_wide;
  logic signed [SumW-1:0]   err_sum_d;
  logic                     brake_d;
  logic signed [PpW-1:0]    pp_d;
  logic signed [PiW-1:0]    pi_d;
  logic signed [PdW-1:0]    pd_d;
  logic signed [DriveW-1:0] drive_d;
  clamp_t                   clamp_d;
  logic [ProdW-1:0]         quot_prod;
  out_item_t                out_d;

  assign rdy4 = !v4_q || out_o.ready;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign in_i.ready = rdy1;
  assign in_acc     = in_i.valid && rdy1;

  assign out_o.valid = v4_q;
  assign out_o.data  = out_q;

  // stage 1: error, error change, saturated sum, direction
  assign err_d   = $signed({1'b0, in_i.data.set_rpm}) - $signed({1'b0, in_i.data.measured_rpm});
  assign delta_d = {err_d[ErrW-1], err_d} - {prev_err_q[ErrW-1], prev_err_q};
  assign sum_wide = {err_sum_q[SumW-1], err_sum_q}
                  + {{(SumW+1-ErrW){err_d[ErrW-1]}}, err_d};
  assign brake_d = in_i.data.set_direction != dir_q;

  always_comb begin
    priority if (sum_wide > (SumW+1)'(SumLimit)) begin
      err_sum_d = SumLimit;
    end else if (sum_wide < -(SumW+1)'(SumLimit)) begin
      err_sum_d = -SumLimit;
    end else begin
      err_sum_d = sum_wide[SumW-1:0];
    end
  end

  // stage 2: gain products
  assign pp_d = $signed({1'b0, kp_q}) * s1_err_q;
  assign pi_d = $signed({1'b0, ki_q}) * s1_sum_q;
  assign pd_d = $signed({1'b0, kd_q}) * s1_delta_q;

  // stage 3: drive sum and clamp
  assign drive_d = DriveW'(s2_pp_q) + DriveW'(s2_pi_q) + DriveW'(s2_pd_q);

  mspr_drive_clamp u_clamp (
    .drive_i (drive_d),
    .clamp_o (clamp_d)
  );

  // stage 4: divide by 25 through the reciprocal, exact for dividends below 2^20
  assign quot_prod = ProdW'(s3_clamp_q.quot_in) * ProdW'(Recip);

  always_comb begin
    out_d.duty        = s3_clamp_q.sat_max ? DutyMax
                                           : quot_prod[RecipShift+DutyW-1:RecipShift];
    out_d.brake       = s3_brake_q;
    out_d.drive_pin_a = !s3_dir_q;
    out_d.drive_pin_h = s3_dir_q;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q       <= KpReset;
      ki_q       <= KiReset;
      kd_q       <= KdReset;
      err_sum_q  <= '0;
      prev_err_q <= '0;
      dir_q      <= 1'b1;
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      v3_q       <= 1'b0;
      v4_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgKp:   kp_q <= cfg_data_i;
          CfgKi:   ki_q <= cfg_data_i;
          CfgKd:   kd_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_acc) begin
        err_sum_q  <= err_sum_d;
        prev_err_q <= err_d;
        dir_q      <= in_i.data.set_direction;
      end
      if (rdy1) v1_q <= in_i.valid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_err_q   <= err_d;
      s1_sum_q   <= err_sum_q;
      s1_delta_q <= delta_d;
      s1_brake_q <= brake_d;
      s1_dir_q   <= in_i.data.set_direction;
    end
    if (rdy2 && v1_q) begin
      s2_pp_q    <= pp_d;
      s2_pi_q    <= pi_d;
      s2_pd_q    <= pd_d;
      s2_brake_q <= s1_brake_q;
      s2_dir_q   <= s1_dir_q;
    end
    if (rdy3 && v2_q) begin
      s3_clamp_q <= clamp_d;
      s3_brake_q <= s2_brake_q;
      s3_dir_q   <= s2_dir_q;
    end
    if (rdy4 && v3_q) begin
      out_q <= out_d;
    end
  end

  a_sum_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_sum_q <= SumLimit) && (err_sum_q >= -SumLimit))
    else $error("error sum outside its limit");

  a_duty_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q |-> (out_q.duty <= DutyMax))
    else $error("duty above 99 percent");

  a_pins_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q |-> (out_q.drive_pin_a != out_q.drive_pin_h))
    else $error("bridge pins not complementary");

  a_prev_err_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (prev_err_q == $past(err_d)))
    else $error("previous error not taken on transfer");

  a_brake_on_turn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_i.data.set_direction != dir_q)) |=> (v1_q && s1_brake_q))
    else $error("direction change without brake");

endmodule

// ===== hw/rtl/mspr_drive_clamp.sv =====
// mspr_drive_clamp: clamps the Q16 drive sum to 0..99 % and prepares the
// dividend for the reciprocal divide. Depends on mspr_pkg.
module mspr_drive_clamp import mspr_pkg::*; (
  input  logic signed [DriveW-1:0] drive_i,
  output clamp_t                   clamp_o
);

  always_comb begin
    clamp_o = '0;
    priority if (drive_i <= 0) begin
      clamp_o.sat_max = 1'b0;
      clamp_o.quot_in = '0;
    end else if (drive_i >= DriveMax) begin
      clamp_o.sat_max = 1'b1;
      clamp_o.quot_in = '0;
    end else begin
      // below DriveMax so the bits above [29] are all zero here
      clamp_o.sat_max = 1'b0;
      clamp_o.quot_in = drive_i[DivShift+QuotW-1:DivShift];
    end
  end

endmodule
